// ===== design/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

	// widths of the stream words
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned MAX_RES   = 4;
	localparam int unsigned RES_CNT_W = 3;
	localparam int unsigned RES_IDX_W = 2;

	// default depth of the result group queue
	localparam int unsigned GRP_DEPTH_DEF = 4;

	// decoder phase
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_STR  = 2'd1;
	localparam logic [1:0] PH_ESC  = 2'd2;
	localparam logic [1:0] PH_HEX  = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_DATA   = 2'd0;
	localparam logic [STAT_W-1:0] ST_CLOSED = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNTERM = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADHEX = 2'd3;

	// characters of interest
	localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;
	localparam logic [BYTE_W-1:0] CH_LOW_B  = 8'h62;
	localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
	localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
	localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
	localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
	localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;

	// all results caused by one input word
	typedef struct packed {
		logic [MAX_RES-1:0][BYTE_W-1:0] dat;
		logic [MAX_RES-1:0][STAT_W-1:0] st;
		logic [RES_CNT_W-1:0]           cnt;
	} grp_t;

	// append one result to a group
	function automatic grp_t grp_push(grp_t g, logic [BYTE_W-1:0] b, logic [STAT_W-1:0] s);
		grp_t r;
		r = g;
		if (g.cnt < RES_CNT_W'(MAX_RES)) begin
			r.dat[g.cnt[RES_IDX_W-1:0]] = b;
			r.st[g.cnt[RES_IDX_W-1:0]]  = s;
			r.cnt = g.cnt + RES_CNT_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/json_string_unescape_utf8_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// data path: input stage register, decode, then the result group queue
// throughput: one input word per cycle when the queue has room; a word
// giving n results takes n transfers; a queue buffers GRP_DEPTH result groups
// reset: arst_n clears the decoder phase, the hex digit state and the queue;
// the decoder starts idle and waits for a word with the start flag
module json_string_unescape_utf8_unit #(
	parameter int unsigned GRP_DEPTH = jsu_pkg::GRP_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output      logic                        s_tready,
	input  wire logic [jsu_pkg::BYTE_W-1:0]  s_tdata,  // [7:0] text_byte
	input  wire logic                        s_tuser,  // [0] start_req
	input  wire logic                        s_tlast,  // end_of_text
	output      logic                        m_tvalid,
	input  wire logic                        m_tready,
	output      logic [jsu_pkg::BYTE_W-1:0]  m_tdata,  // [7:0] out_byte
	output      logic [jsu_pkg::STAT_W-1:0]  m_tuser,  // [1:0] status
	output      logic                        m_tlast   // last_of_run
);
	import jsu_pkg::*;

	localparam int unsigned PTR_W = (GRP_DEPTH > 1) ? $clog2(GRP_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(GRP_DEPTH + 1);
	localparam logic [CNT_W:0] ROOM = (CNT_W+1)'(GRP_DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(GRP_DEPTH - 1);

	// input stage
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;
	logic              last_s1;

	// decoder state
	logic [1:0]  phase_q;
	logic        delim_single_q;
	logic [15:0] hex_accum_q;
	logic [2:0]  hex_seen_q;

	logic [1:0]  phase_d;
	logic        delim_single_d;
	logic [15:0] hex_accum_d;
	logic [2:0]  hex_seen_d;
	grp_t        grp_d;

	// result group queue
	grp_t                 fifo_q [GRP_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic [RES_IDX_W-1:0] idx_q;
	grp_t                 head;
	logic                 wr_en;
	logic                 pop;
	logic                 pop_grp;

	// accept while a group slot stays free for the word in the input stage
	assign s_tready = ({1'b0, count_q} + (CNT_W+1)'(v_s1)) <= ROOM;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	// one decoding step on the registered word
	always_comb begin
		logic [BYTE_W-1:0] m;
		logic              is_hex;
		logic [3:0]        dig;
		logic [15:0]       acc;

		phase_d        = phase_q;
		delim_single_d = delim_single_q;
		hex_accum_d    = hex_accum_q;
		hex_seen_d     = hex_seen_q;
		grp_d          = '0;
		m              = '0;
		is_hex         = 1'b0;
		dig            = '0;
		acc            = '0;

		// hex digit value
		if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
			is_hex = 1'b1;
			dig    = byte_s1[3:0];
		end else if ((byte_s1 >= 8'h61 && byte_s1 <= 8'h66) ||
			(byte_s1 >= 8'h41 && byte_s1 <= 8'h46)) begin
			is_hex = 1'b1;
			dig    = byte_s1[3:0] + 4'd9;
		end

		if (start_s1) begin
			// opening quote picks the delimiter
			delim_single_d = (byte_s1 == CH_SQUOTE);
			hex_accum_d    = '0;
			hex_seen_d     = '0;
			phase_d        = PH_STR;
			if (last_s1) begin
				grp_d   = grp_push(grp_d, '0, ST_UNTERM);
				phase_d = PH_IDLE;
			end
		end else begin
			case (phase_q)
				PH_STR: begin
					if (byte_s1 == CH_DQUOTE || byte_s1 == CH_SQUOTE) begin
						if ((byte_s1 == CH_SQUOTE) == delim_single_q) begin
							grp_d   = grp_push(grp_d, '0, ST_CLOSED);
							phase_d = PH_IDLE;
						end else begin
							grp_d = grp_push(grp_d, byte_s1, ST_DATA);
							if (last_s1) begin
								grp_d   = grp_push(grp_d, '0, ST_UNTERM);
								phase_d = PH_IDLE;
							end
						end
					end else if (last_s1) begin
						grp_d   = grp_push(grp_d, '0, ST_UNTERM);
						phase_d = PH_IDLE;
					end else if (byte_s1 == CH_BSLASH) begin
						phase_d = PH_ESC;
					end else begin
						grp_d = grp_push(grp_d, byte_s1, ST_DATA);
					end
				end
				PH_ESC: begin
					if (byte_s1 == CH_LOW_U) begin
						hex_accum_d = '0;
						hex_seen_d  = '0;
						if (last_s1) begin
							grp_d   = grp_push(grp_d, '0, ST_UNTERM);
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_HEX;
						end
					end else begin
						// single-byte escapes
						case (byte_s1)
							CH_BSLASH: m = CH_BSLASH;
							CH_SLASH:  m = CH_SLASH;
							CH_DQUOTE: m = CH_DQUOTE;
							CH_SQUOTE: m = CH_SQUOTE;
							CH_LOW_B:  m = CH_BS;
							CH_LOW_F:  m = CH_FF;
							CH_LOW_R:  m = CH_CR;
							CH_LOW_N:  m = CH_LF;
							CH_LOW_T:  m = CH_TAB;
							default:   m = '0;
						endcase
						if (m != '0) begin
							grp_d = grp_push(grp_d, m, ST_DATA);
						end else begin
							grp_d = grp_push(grp_d, CH_BSLASH, ST_DATA);
							grp_d = grp_push(grp_d, byte_s1, ST_DATA);
						end
						phase_d = PH_STR;
						if (last_s1) begin
							grp_d   = grp_push(grp_d, '0, ST_UNTERM);
							phase_d = PH_IDLE;
						end
					end
				end
				PH_HEX: begin
					acc = {hex_accum_q[11:0], dig};
					if (last_s1 && hex_seen_q < 3'd3) begin
						grp_d   = grp_push(grp_d, '0, ST_UNTERM);
						phase_d = PH_IDLE;
					end else if (!is_hex) begin
						grp_d   = grp_push(grp_d, '0, ST_BADHEX);
						phase_d = PH_IDLE;
					end else begin
						hex_accum_d = acc;
						hex_seen_d  = hex_seen_q + 3'd1;
						if (hex_seen_q == 3'd3) begin
							// utf-8 encoding of the code unit
							if (acc < 16'd128) begin
								grp_d = grp_push(grp_d, acc[7:0], ST_DATA);
							end else if (acc < 16'd2048) begin
								grp_d = grp_push(grp_d, {3'b110, acc[10:6]}, ST_DATA);
								grp_d = grp_push(grp_d, {2'b10, acc[5:0]}, ST_DATA);
							end else begin
								grp_d = grp_push(grp_d, {4'b1110, acc[15:12]}, ST_DATA);
								grp_d = grp_push(grp_d, {2'b10, acc[11:6]}, ST_DATA);
								grp_d = grp_push(grp_d, {2'b10, acc[5:0]}, ST_DATA);
							end
							hex_seen_d = '0;
							phase_d    = PH_STR;
							if (last_s1) begin
								grp_d   = grp_push(grp_d, '0, ST_UNTERM);
								phase_d = PH_IDLE;
							end
						end
					end
				end
				default: begin
					// idle: bytes without the start flag are ignored
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// decoder state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			delim_single_q <= 1'b0;
			hex_accum_q    <= '0;
			hex_seen_q     <= '0;
		end else if (v_s1) begin
			phase_q        <= phase_d;
			delim_single_q <= delim_single_d;
			hex_accum_q    <= hex_accum_d;
			hex_seen_q     <= hex_seen_d;
		end
	end

	// queue head and output word
	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = head.dat[idx_q];
	assign m_tuser  = head.st[idx_q];
	assign m_tlast  = ({1'b0, idx_q} == (head.cnt - RES_CNT_W'(1)));
	assign pop      = m_tvalid && m_tready;
	assign pop_grp  = pop && m_tlast;
	assign wr_en    = v_s1 && (grp_d.cnt != '0);

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_ptr_q] <= grp_d;
		end
	end

	// queue pointers and drain index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			idx_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop_grp) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
				idx_q    <= '0;
			end else if (pop) begin
				idx_q <= idx_q + RES_IDX_W'(1);
			end
			count_q <= count_q + CNT_W'(wr_en) - CNT_W'(pop_grp);
		end
	end

endmodule
`default_nettype wire
